>>> hw/rtl/scc_pkg.sv
// ----------------------------------------------------------------------------
// scc_pkg
// Shared sizes, command codes and helpers for the strongly connected
// components unit.
// ----------------------------------------------------------------------------
package scc_pkg;

    localparam int MAX_VERTS = 64;
    localparam int MAX_EDGES = 1024;
    localparam int VW        = $clog2(MAX_VERTS);   // 0-based vertex width
    localparam int EAW       = $clog2(MAX_EDGES);   // edge store address width
    localparam int ECW       = EAW + 1;             // edge count / cursor width
    localparam int NW        = VW + 1;              // vertex count width

    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_RUN   = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    typedef logic [VW-1:0]        vert_t;
    typedef logic [MAX_VERTS-1:0] vmask_t;

    typedef struct packed {
        vert_t            v;
        logic [ECW-1:0]   cur;
    } frame_t;

    typedef struct packed {
        vert_t tail;
        vert_t head;
    } edge_t;

    // index of highest set bit (0 when empty)
    function automatic vert_t highest_bit(input vmask_t m);
        vert_t r;
        r = '0;
        for (int i = 0; i < MAX_VERTS; i++)
        begin
            if (m[i])
                r = vert_t'(i);
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/strongly_connected_components_unit.sv
// ----------------------------------------------------------------------------
// strongly_connected_components_unit
// Edge store plus two-pass depth-first component search.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel (cmd_valid/cmd_stall): command, source_vertex,
//   target_vertex. Add and clear give no result word.
//   Run walks the edge store and emits one word per vertex on the result
//   channel (res_valid/res_stall): vertex, component_end, run_end,
//   edges_dropped.
//   A run makes a first depth-first pass that scans the edge store for
//   each stack frame, builds an adjacency row per vertex from the stored
//   edges, then makes a second pass over the rows in reverse finish order.
//   Run state lives in the edge, stack, finish-order and row memories.
//   cmd_stall is high for the whole run. A result word is held one vertex
//   back so its end flags are known; a stalled result register halts the
//   sequencer without losing words.
//   Only write vertex_count (cfg_we/cfg_wdata) while idle; not enforced.
//   Reset clears the edge count, the drop flag and vertex_count; the
//   memories are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module strongly_connected_components_unit
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [6:0] cfg_wdata,
    input  logic       cmd_valid,
    output logic       cmd_stall,
    input  logic [1:0] command,
    input  logic [6:0] source_vertex,
    input  logic [6:0] target_vertex,
    output logic       res_valid,
    input  logic       res_stall,
    output logic [6:0] vertex,
    output logic       component_end,
    output logic       run_end,
    output logic       edges_dropped
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_P1STRT = 4'd1;
    localparam logic [3:0] S_P1SCAN = 4'd2;
    localparam logic [3:0] S_P1CHK  = 4'd3;
    localparam logic [3:0] S_P1POP  = 4'd4;
    localparam logic [3:0] S_MRD    = 4'd5;
    localparam logic [3:0] S_MEW    = 4'd6;
    localparam logic [3:0] S_MWR    = 4'd7;
    localparam logic [3:0] S_P2ROOT = 4'd8;
    localparam logic [3:0] S_P2RW   = 4'd9;
    localparam logic [3:0] S_P2READ = 4'd10;
    localparam logic [3:0] S_P2PICK = 4'd11;
    localparam logic [3:0] S_P2POP  = 4'd12;
    localparam logic [3:0] S_EMIT   = 4'd13;
    localparam logic [3:0] S_FINAL  = 4'd14;

    localparam int VW  = scc_pkg::VW;
    localparam int EAW = scc_pkg::EAW;
    localparam int ECW = scc_pkg::ECW;
    localparam int NW  = scc_pkg::NW;

    // memories
    scc_pkg::edge_t  edge_mem  [scc_pkg::MAX_EDGES];
    scc_pkg::frame_t stack_mem [scc_pkg::MAX_VERTS];
    scc_pkg::vert_t  fin_mem   [scc_pkg::MAX_VERTS];
    scc_pkg::vmask_t row_mem   [scc_pkg::MAX_VERTS];

    scc_pkg::edge_t  edge_rd_reg;
    scc_pkg::frame_t stack_rd_reg;
    scc_pkg::vert_t  fin_rd_reg;
    scc_pkg::vmask_t row_rd_reg;

    logic              edge_we;
    logic [EAW-1:0]    edge_waddr, edge_raddr;
    scc_pkg::edge_t    edge_wdata;
    logic              stack_we;
    logic [VW-1:0]     stack_waddr, stack_raddr;
    scc_pkg::frame_t   stack_wdata;
    logic              fin_we;
    logic [VW-1:0]     fin_waddr, fin_raddr;
    logic              row_we;
    logic [VW-1:0]     row_waddr, row_raddr;
    scc_pkg::vmask_t   row_wdata;

    // control state
    logic [3:0]        state_reg, state_next;
    logic [NW-1:0]     vcount_reg, vcount_next;
    logic [ECW-1:0]    total_reg, total_next;
    logic              dropped_reg, dropped_next;
    scc_pkg::vmask_t   visited_reg, visited_next;
    scc_pkg::vmask_t   rowval_reg, rowval_next;
    logic [NW-1:0]     fcount_reg, fcount_next;
    logic [NW-1:0]     sidx_reg, sidx_next;
    logic [NW-1:0]     depth_reg, depth_next;
    scc_pkg::vert_t    cv_reg, cv_next;
    logic [ECW-1:0]    cur_reg, cur_next;
    logic [ECW-1:0]    eidx_reg, eidx_next;
    scc_pkg::vert_t    newv_reg, newv_next;
    logic              newc_reg, newc_next;
    scc_pkg::vert_t    hold_reg, hold_next;
    logic              holdv_reg, holdv_next;

    logic              ovalid_reg, ovalid_next;
    scc_pkg::vert_t    ov_reg, ov_next;
    logic              ocomp_reg, ocomp_next;
    logic              orun_reg, orun_next;
    logic              odrop_reg, odrop_next;

    logic [NW-1:0]     n;
    logic              out_free;
    logic              accept;
    scc_pkg::vmask_t   row_data;
    scc_pkg::vmask_t   cand;
    scc_pkg::vert_t    pick;

    assign n        = (vcount_reg > NW'(scc_pkg::MAX_VERTS)) ?
                      NW'(scc_pkg::MAX_VERTS) : vcount_reg;
    assign out_free = !ovalid_reg || !res_stall;
    assign accept   = cmd_valid && !cmd_stall;
    assign row_data = rowval_reg[cv_reg] ? row_rd_reg : '0;
    assign cand     = row_data & ~visited_reg;
    assign pick     = scc_pkg::highest_bit(cand);

    assign cmd_stall     = (state_reg != S_IDLE);
    assign res_valid     = ovalid_reg;
    assign vertex        = {1'b0, ov_reg} + 7'd1;
    assign component_end = ocomp_reg;
    assign run_end       = orun_reg;
    assign edges_dropped = odrop_reg;

    always_ff @(posedge clk)
    begin
        if (edge_we)
            edge_mem[edge_waddr] <= edge_wdata;
        edge_rd_reg <= edge_mem[edge_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (stack_we)
            stack_mem[stack_waddr] <= stack_wdata;
        stack_rd_reg <= stack_mem[stack_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (fin_we)
            fin_mem[fin_waddr] <= cv_reg;
        fin_rd_reg <= fin_mem[fin_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (row_we)
            row_mem[row_waddr] <= row_wdata;
        row_rd_reg <= row_mem[row_raddr];
    end

    always_comb
    begin
        state_next   = state_reg;
        vcount_next  = cfg_we ? cfg_wdata : vcount_reg;
        total_next   = total_reg;
        dropped_next = dropped_reg;
        visited_next = visited_reg;
        rowval_next  = rowval_reg;
        fcount_next  = fcount_reg;
        sidx_next    = sidx_reg;
        depth_next   = depth_reg;
        cv_next      = cv_reg;
        cur_next     = cur_reg;
        eidx_next    = eidx_reg;
        newv_next    = newv_reg;
        newc_next    = newc_reg;
        hold_next    = hold_reg;
        holdv_next   = holdv_reg;
        ovalid_next  = ovalid_reg && res_stall;
        ov_next      = ov_reg;
        ocomp_next   = ocomp_reg;
        orun_next    = orun_reg;
        odrop_next   = odrop_reg;

        edge_we      = 1'b0;
        edge_waddr   = total_reg[EAW-1:0];
        edge_wdata   = '{tail: VW'(source_vertex - 7'd1), head: VW'(target_vertex - 7'd1)};
        edge_raddr   = eidx_reg[EAW-1:0];
        stack_we     = 1'b0;
        stack_waddr  = VW'(depth_reg - NW'(1));
        stack_wdata  = '{v: cv_reg, cur: cur_reg};
        stack_raddr  = VW'(depth_reg - NW'(2));
        fin_we       = 1'b0;
        fin_waddr    = fcount_reg[VW-1:0];
        fin_raddr    = VW'(fcount_reg - NW'(1));
        row_we       = 1'b0;
        row_waddr    = edge_rd_reg.head;
        row_wdata    = (rowval_reg[edge_rd_reg.head] ? row_rd_reg : '0)
                       | (scc_pkg::vmask_t'(1) << edge_rd_reg.tail);
        row_raddr    = edge_rd_reg.head;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (command)
                        scc_pkg::CMD_ADD:
                        begin
                            if (source_vertex == 7'd0 || source_vertex > n ||
                                target_vertex == 7'd0 || target_vertex > n ||
                                total_reg >= ECW'(scc_pkg::MAX_EDGES))
                                dropped_next = 1'b1;
                            else
                            begin
                                edge_we    = 1'b1;
                                total_next = total_reg + ECW'(1);
                            end
                        end
                        scc_pkg::CMD_CLEAR:
                        begin
                            total_next   = '0;
                            dropped_next = 1'b0;
                        end
                        scc_pkg::CMD_RUN:
                        begin
                            if (n != '0)
                            begin
                                visited_next = '0;
                                fcount_next  = '0;
                                sidx_next    = '0;
                                state_next   = S_P1STRT;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_P1STRT:
            begin
                if (sidx_reg == n)
                begin
                    rowval_next = '0;
                    eidx_next   = '0;
                    state_next  = S_MRD;
                end
                else if (visited_reg[sidx_reg[VW-1:0]])
                    sidx_next = sidx_reg + NW'(1);
                else
                begin
                    visited_next[sidx_reg[VW-1:0]] = 1'b1;
                    cv_next    = sidx_reg[VW-1:0];
                    cur_next   = total_reg;
                    depth_next = NW'(1);
                    state_next = S_P1SCAN;
                end
            end

            S_P1SCAN:
            begin
                if (cur_reg == '0)
                begin
                    fin_we      = 1'b1;
                    fcount_next = fcount_reg + NW'(1);
                    depth_next  = depth_reg - NW'(1);
                    if (depth_reg == NW'(1))
                    begin
                        sidx_next  = sidx_reg + NW'(1);
                        state_next = S_P1STRT;
                    end
                    else
                        state_next = S_P1POP;
                end
                else
                begin
                    edge_raddr = EAW'(cur_reg - ECW'(1));
                    cur_next   = cur_reg - ECW'(1);
                    state_next = S_P1CHK;
                end
            end

            S_P1CHK:
            begin
                if (edge_rd_reg.tail == cv_reg && {1'b0, edge_rd_reg.head} < n &&
                    !visited_reg[edge_rd_reg.head])
                begin
                    stack_we   = 1'b1;
                    visited_next[edge_rd_reg.head] = 1'b1;
                    cv_next    = edge_rd_reg.head;
                    cur_next   = total_reg;
                    depth_next = depth_reg + NW'(1);
                end
                state_next = S_P1SCAN;
            end

            S_P1POP:
            begin
                cv_next    = stack_rd_reg.v;
                cur_next   = stack_rd_reg.cur;
                state_next = S_P1SCAN;
            end

            S_MRD:
            begin
                if (eidx_reg == total_reg)
                begin
                    visited_next = '0;
                    holdv_next   = 1'b0;
                    state_next   = S_P2ROOT;
                end
                else
                    state_next = S_MEW;
            end

            S_MEW:
            begin
                if ({1'b0, edge_rd_reg.tail} < n && {1'b0, edge_rd_reg.head} < n)
                    state_next = S_MWR;
                else
                begin
                    eidx_next  = eidx_reg + ECW'(1);
                    state_next = S_MRD;
                end
            end

            S_MWR:
            begin
                row_we      = 1'b1;
                rowval_next[edge_rd_reg.head] = 1'b1;
                eidx_next   = eidx_reg + ECW'(1);
                edge_raddr  = EAW'(eidx_reg + ECW'(1));
                state_next  = S_MRD;
            end

            S_P2ROOT:
            begin
                if (fcount_reg == '0)
                    state_next = S_FINAL;
                else
                begin
                    fcount_next = fcount_reg - NW'(1);
                    state_next  = S_P2RW;
                end
            end

            S_P2RW:
            begin
                if (visited_reg[fin_rd_reg])
                    state_next = S_P2ROOT;
                else
                begin
                    visited_next[fin_rd_reg] = 1'b1;
                    cv_next    = fin_rd_reg;
                    depth_next = NW'(1);
                    newv_next  = fin_rd_reg;
                    newc_next  = 1'b1;
                    state_next = S_EMIT;
                end
            end

            S_P2READ:
            begin
                row_raddr  = cv_reg;
                state_next = S_P2PICK;
            end

            S_P2PICK:
            begin
                if (cand != '0)
                begin
                    stack_we     = 1'b1;
                    stack_wdata  = '{v: cv_reg, cur: '0};
                    visited_next[pick] = 1'b1;
                    depth_next   = depth_reg + NW'(1);
                    cv_next      = pick;
                    newv_next    = pick;
                    newc_next    = 1'b0;
                    state_next   = S_EMIT;
                end
                else
                begin
                    depth_next = depth_reg - NW'(1);
                    if (depth_reg == NW'(1))
                        state_next = S_P2ROOT;
                    else
                        state_next = S_P2POP;
                end
            end

            S_P2POP:
            begin
                cv_next    = stack_rd_reg.v;
                state_next = S_P2READ;
            end

            S_EMIT:
            begin
                if (!holdv_reg)
                begin
                    hold_next  = newv_reg;
                    holdv_next = 1'b1;
                    state_next = S_P2READ;
                end
                else if (out_free)
                begin
                    ovalid_next = 1'b1;
                    ov_next     = hold_reg;
                    ocomp_next  = newc_reg;
                    orun_next   = 1'b0;
                    odrop_next  = dropped_reg;
                    hold_next   = newv_reg;
                    state_next  = S_P2READ;
                end
            end

            S_FINAL:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    ov_next     = hold_reg;
                    ocomp_next  = 1'b1;
                    orun_next   = 1'b1;
                    odrop_next  = dropped_reg;
                    holdv_next  = 1'b0;
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (state_reg == S_MRD)
            edge_raddr = eidx_reg[EAW-1:0];
        if (state_reg == S_P2ROOT)
            fin_raddr = VW'(fcount_reg - NW'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            vcount_reg  <= '0;
            total_reg   <= '0;
            dropped_reg <= 1'b0;
            visited_reg <= '0;
            rowval_reg  <= '0;
            fcount_reg  <= '0;
            sidx_reg    <= '0;
            depth_reg   <= '0;
            eidx_reg    <= '0;
            holdv_reg   <= 1'b0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            vcount_reg  <= vcount_next;
            total_reg   <= total_next;
            dropped_reg <= dropped_next;
            visited_reg <= visited_next;
            rowval_reg  <= rowval_next;
            fcount_reg  <= fcount_next;
            sidx_reg    <= sidx_next;
            depth_reg   <= depth_next;
            eidx_reg    <= eidx_next;
            holdv_reg   <= holdv_next;
            ovalid_reg  <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cv_reg    <= cv_next;
        cur_reg   <= cur_next;
        newv_reg  <= newv_next;
        newc_reg  <= newc_next;
        hold_reg  <= hold_next;
        ov_reg    <= ov_next;
        ocomp_reg <= ocomp_next;
        orun_reg  <= orun_next;
        odrop_reg <= odrop_next;
    end

endmodule
